// ===== rtl/triangle_primitive_assembler_assert.svh =====
// Assertion macros for the triangle primitive assembler.
// Every macro expects clk and arst_n to be visible where it is used.
`ifndef TRIANGLE_PRIMITIVE_ASSEMBLER_ASSERT_SVH
`define TRIANGLE_PRIMITIVE_ASSEMBLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPA_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tpa assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TPA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tpa assertion failed");

`endif

// ===== rtl/tpa_pkg.sv =====
// Shared types and constants of the triangle primitive assembler.
// No dependencies; the top level, front end, queue and emitter refer to it.
package tpa_pkg;

	typedef enum logic {
		OP_BEGIN  = 1'b0,
		OP_VERTEX = 1'b1
	} op_e_t;

	typedef enum logic [1:0] {
		MODE_TRI   = 2'd0,
		MODE_FAN   = 2'd1,
		MODE_STRIP = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_SECOND = 2'd1,
		PH_RUN    = 2'd2
	} phase_t;

	// Each queued command carries three vertex slots; slot 2 is always the new vertex.
	localparam int unsigned NUM_SLOTS = 3;
	localparam logic [1:0] SLOT_FIRST = 2'd0;
	localparam logic [1:0] SLOT_LAST = 2'd2;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QLEVEL_W = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== rtl/tpa_in_if.sv =====
// Input channel of the triangle primitive assembler: begin and vertex items.
// Valid/ready handshake; depends on nothing else.
interface tpa_in_if #(
	parameter int COORD_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic [1:0]                    prim_type;
	logic signed [COORD_WIDTH-1:0] vert_x;
	logic signed [COORD_WIDTH-1:0] vert_y;

	modport source (output valid, op, prim_type, vert_x, vert_y, input ready);
	modport sink (input valid, op, prim_type, vert_x, vert_y, output ready);
endinterface

// ===== rtl/tpa_out_if.sv =====
// Output channel of the triangle primitive assembler: one list vertex per item.
// Valid/ready handshake; depends on nothing else.
interface tpa_out_if #(
	parameter int COORD_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] out_x;
	logic signed [COORD_WIDTH-1:0] out_y;
	logic                          last;

	modport source (output valid, out_x, out_y, last, input ready);
	modport sink (input valid, out_x, out_y, last, output ready);
endinterface

// ===== rtl/triangle_primitive_assembler.sv =====
// Triangle primitive assembler.
//
// Channels: "vertices" takes begin items (op 0, prim_type picks list, fan,
// strip or unsupported) and vertex items (op 1, vert_x/vert_y in signed
// Q16.16). "triangles" gives plain triangle-list vertices, one per item,
// with last set on the final vertex produced by one input item.
// A list vertex produces one item; a fan or strip vertex from the third on
// produces three; begin items, the first two fan/strip vertices and
// vertices of an unsupported type produce none.
// A vertex's first result passes through the command queue and then the
// emitter's command register before it is valid. Throughput: the single
// output port sets the pace, so a fan or strip vertex takes three output
// items and a list vertex one; the front end keeps accepting while a
// two-entry command queue has room, and items that produce nothing are
// taken every cycle while it has room.
// Reset clears the mode to unsupported, the phase and parity to zero and
// empties the queue; no clearing pass is needed.
// When the receiver stalls, the current vertex holds on the output, the
// queue fills, and then the input channel drops ready.
// Depends on tpa_pkg, the two channel interfaces and the assert macros.
`include "triangle_primitive_assembler_assert.svh"

module triangle_primitive_assembler #(
	parameter int COORD_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	tpa_in_if.sink    vertices,
	tpa_out_if.source triangles
);

	localparam int CMD_W = 6 * COORD_WIDTH + 1;

	logic                         push;
	logic [CMD_W-1:0]             push_data;
	logic                         pop;
	logic [CMD_W-1:0]             pop_data;
	logic                         q_full;
	logic                         q_empty;
	logic [tpa_pkg::QLEVEL_W-1:0] q_level;

	tpa_front #(
		.COORD_WIDTH(COORD_WIDTH),
		.CMD_W(CMD_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.vertices(vertices),
		.full(q_full),
		.push(push),
		.push_data(push_data)
	);

	tpa_queue #(
		.CMD_W(CMD_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.pop_data(pop_data),
		.full(q_full),
		.empty(q_empty),
		.level(q_level)
	);

	tpa_back #(
		.COORD_WIDTH(COORD_WIDTH),
		.CMD_W(CMD_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(q_empty),
		.pop_data(pop_data),
		.pop(pop),
		.triangles(triangles)
	);

	// The queue can only fill up while the emitter is holding a command.
	`TPA_ASSERT_IMPLY(a_full_means_busy, q_full, triangles.valid)
	// The front end never pushes into a full queue.
	`TPA_ASSERT_IMPLY(a_no_push_when_full, push, !q_full)
	// Handing over the final vertex with nothing queued leaves the output idle.
	`TPA_ASSERT_NEXT(a_drain_to_idle,
		triangles.valid && triangles.ready && triangles.last && q_empty, !triangles.valid)
	// The level never runs past the queue depth.
	`TPA_ASSERT_IMPLY(a_level_bound, 1'b1, q_level <= tpa_pkg::QUEUE_DEPTH)

endmodule

// ===== rtl/tpa_front.sv =====
// Front end: accepts begin and vertex items, tracks the primitive state and
// builds one emit command per producing vertex. Depends on tpa_pkg and tpa_in_if.
module tpa_front #(
	parameter int COORD_WIDTH = 32,
	parameter int CMD_W = 6 * COORD_WIDTH + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	tpa_in_if.sink           vertices,
	input  logic             full,
	output logic             push,
	output logic [CMD_W-1:0] push_data
);

	logic                   accept;
	logic                   is_vertex;
	logic                   single;
	logic [COORD_WIDTH-1:0] e0_x, e0_y, e1_x, e1_y;

	tpa_pkg::mode_t  mode_q;
	tpa_pkg::phase_t phase_q;
	logic            parity_q;
	logic [COORD_WIDTH-1:0] origin_x_q, origin_y_q;
	logic [COORD_WIDTH-1:0] prev_x_q, prev_y_q;
	logic [COORD_WIDTH-1:0] pprev_x_q, pprev_y_q;

	assign vertices.ready = !full;
	assign accept = vertices.valid && !full;
	assign is_vertex = (vertices.op == tpa_pkg::OP_VERTEX);

	always_comb begin
		push = 1'b0;
		single = 1'b0;
		e0_x = prev_x_q;
		e0_y = prev_y_q;
		e1_x = pprev_x_q;
		e1_y = pprev_y_q;
		if (accept && is_vertex) begin
			case (mode_q)
				tpa_pkg::MODE_TRI: begin
					push = 1'b1;
					single = 1'b1;
				end
				tpa_pkg::MODE_FAN: begin
					if (phase_q == tpa_pkg::PH_RUN) begin
						push = 1'b1;
						e0_x = origin_x_q;
						e0_y = origin_y_q;
						e1_x = prev_x_q;
						e1_y = prev_y_q;
					end
				end
				tpa_pkg::MODE_STRIP: begin
					if (phase_q == tpa_pkg::PH_RUN) begin
						push = 1'b1;
						// Even parity swaps the two stored vertices.
						if (!parity_q) begin
							e0_x = pprev_x_q;
							e0_y = pprev_y_q;
							e1_x = prev_x_q;
							e1_y = prev_y_q;
						end
					end
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	assign push_data = {single, vertices.vert_y, vertices.vert_x, e1_y, e1_x, e0_y, e0_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= tpa_pkg::MODE_NONE;
			phase_q <= tpa_pkg::PH_FIRST;
			parity_q <= 1'b0;
			origin_x_q <= '0;
			origin_y_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			pprev_x_q <= '0;
			pprev_y_q <= '0;
		end else if (accept) begin
			if (!is_vertex) begin
				mode_q <= tpa_pkg::mode_t'(vertices.prim_type);
				phase_q <= tpa_pkg::PH_FIRST;
				parity_q <= 1'b0;
			end else if (mode_q == tpa_pkg::MODE_FAN) begin
				case (phase_q)
					tpa_pkg::PH_FIRST: begin
						origin_x_q <= vertices.vert_x;
						origin_y_q <= vertices.vert_y;
						phase_q <= tpa_pkg::PH_SECOND;
					end
					tpa_pkg::PH_SECOND: begin
						prev_x_q <= vertices.vert_x;
						prev_y_q <= vertices.vert_y;
						phase_q <= tpa_pkg::PH_RUN;
					end
					default: begin
						prev_x_q <= vertices.vert_x;
						prev_y_q <= vertices.vert_y;
					end
				endcase
			end else if (mode_q == tpa_pkg::MODE_STRIP) begin
				case (phase_q)
					tpa_pkg::PH_FIRST: begin
						pprev_x_q <= vertices.vert_x;
						pprev_y_q <= vertices.vert_y;
						phase_q <= tpa_pkg::PH_SECOND;
					end
					tpa_pkg::PH_SECOND: begin
						prev_x_q <= vertices.vert_x;
						prev_y_q <= vertices.vert_y;
						phase_q <= tpa_pkg::PH_RUN;
						parity_q <= ~parity_q;
					end
					default: begin
						pprev_x_q <= prev_x_q;
						pprev_y_q <= prev_y_q;
						prev_x_q <= vertices.vert_x;
						prev_y_q <= vertices.vert_y;
						parity_q <= ~parity_q;
					end
				endcase
			end
		end
	end

endmodule

// ===== rtl/tpa_queue.sv =====
// Short command queue between the front end and the emitter.
// Depends on tpa_pkg for its depth.
module tpa_queue #(
	parameter int CMD_W = 193
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic [CMD_W-1:0]              push_data,
	input  logic                          pop,
	output logic [CMD_W-1:0]              pop_data,
	output logic                          full,
	output logic                          empty,
	output logic [tpa_pkg::QLEVEL_W-1:0]  level
);

	logic [CMD_W-1:0]            slots_q [tpa_pkg::QUEUE_DEPTH];
	logic [tpa_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [tpa_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [tpa_pkg::QLEVEL_W-1:0] level_q;
	logic                         do_push;
	logic                         do_pop;

	assign full = (level_q == tpa_pkg::QLEVEL_W'(tpa_pkg::QUEUE_DEPTH));
	assign empty = (level_q == '0);
	assign level = level_q;
	assign pop_data = slots_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == tpa_pkg::QPTR_W'(tpa_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == tpa_pkg::QPTR_W'(tpa_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/tpa_back.sv =====
// Emitter: takes one command at a time from the queue and sends its vertices
// one per item, flagging the final one. Depends on tpa_pkg and tpa_out_if.
module tpa_back #(
	parameter int COORD_WIDTH = 32,
	parameter int CMD_W = 6 * COORD_WIDTH + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  logic [CMD_W-1:0] pop_data,
	output logic             pop,
	tpa_out_if.source        triangles
);

	logic [CMD_W-2:0] cmd_q;
	logic [1:0]       slot_q;
	logic             busy_q;
	logic             done;

	assign done = triangles.ready && (slot_q == tpa_pkg::SLOT_LAST);
	// A new command loads on the cycle the previous one hands over its final vertex.
	assign pop = !empty && (!busy_q || done);

	assign triangles.valid = busy_q;
	assign triangles.last = (slot_q == tpa_pkg::SLOT_LAST);

	always_comb begin
		case (slot_q)
			tpa_pkg::SLOT_FIRST: begin
				triangles.out_x = cmd_q[COORD_WIDTH-1:0];
				triangles.out_y = cmd_q[2*COORD_WIDTH-1:COORD_WIDTH];
			end
			tpa_pkg::SLOT_LAST: begin
				triangles.out_x = cmd_q[5*COORD_WIDTH-1:4*COORD_WIDTH];
				triangles.out_y = cmd_q[6*COORD_WIDTH-1:5*COORD_WIDTH];
			end
			default: begin
				triangles.out_x = cmd_q[3*COORD_WIDTH-1:2*COORD_WIDTH];
				triangles.out_y = cmd_q[4*COORD_WIDTH-1:3*COORD_WIDTH];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= pop_data[CMD_W-2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			slot_q <= tpa_pkg::SLOT_FIRST;
		end else if (pop) begin
			busy_q <= 1'b1;
			// A list vertex is a single-vertex command: start at the last slot.
			slot_q <= pop_data[CMD_W-1] ? tpa_pkg::SLOT_LAST : tpa_pkg::SLOT_FIRST;
		end else if (busy_q && triangles.ready) begin
			if (slot_q == tpa_pkg::SLOT_LAST) begin
				busy_q <= 1'b0;
			end else begin
				slot_q <= slot_q + 2'd1;
			end
		end
	end

endmodule
